// ----- design/m68kpd_pkg.sv -----
// Package for the 68000 instruction pre-decoder: class and flow codes,
// the classified-item record passed from front to back. No dependencies.
package m68kpd_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [5:0] {
        CL_TRUNC = 6'd0, CL_BRA = 6'd1, CL_BSR = 6'd2, CL_BCC = 6'd3,
        CL_TRAP = 6'd4, CL_RTS = 6'd5, CL_RTE = 6'd6, CL_RTR = 6'd7,
        CL_NOP = 6'd8, CL_RESET = 6'd9, CL_TRAPV = 6'd10, CL_STOP = 6'd11,
        CL_RTD = 6'd12, CL_LINK = 6'd13, CL_UNLK = 6'd14, CL_MOVE_USP = 6'd15,
        CL_JSR = 6'd16, CL_JMP = 6'd17, CL_MOVEQ = 6'd18, CL_MOVE = 6'd19,
        CL_IMMEDIATE = 6'd20, CL_STATIC_BIT = 6'd21, CL_DBCC = 6'd22,
        CL_SCC = 6'd23, CL_SUBQ = 6'd24, CL_ADDQ = 6'd25, CL_LEA = 6'd26,
        CL_PEA = 6'd27, CL_MOVEM = 6'd28, CL_SWAP = 6'd29, CL_EXT = 6'd30,
        CL_MOVE_STATUS = 6'd31, CL_UNARY = 6'd32, CL_BINARY = 6'd33,
        CL_SHIFT = 6'd34, CL_UNSUPPORTED = 6'd35
    } iclass_t;

    typedef enum logic [2:0] {
        FL_NONE = 3'd0, FL_DBRANCH = 3'd1, FL_DJUMP = 3'd2, FL_DCALL = 3'd3,
        FL_IJUMP = 3'd4, FL_ICALL = 3'd5, FL_RETURN = 3'd6, FL_UNSUP = 3'd7
    } flow_t;

    // Target source selected by the front end
    typedef enum logic [1:0] {
        TG_NONE = 2'd0, TG_REL = 2'd1, TG_ABS = 2'd2
    } tgt_t;

    // Classified item: length check and target add are left to the back end
    typedef struct packed {
        logic        trunc;
        logic [3:0]  avail;
        logic [3:0]  len;
        logic        ok;
        iclass_t     cls;
        flow_t       flow;
        tgt_t        tsel;
        logic [23:0] pc;
        logic [31:0] tval;   // displacement (sign-extended) or absolute long
        logic        cvalid;
        logic [3:0]  cond;
    } pre_item_t;

    typedef struct packed {
        logic [3:0]  length_bytes;
        logic        supported;
        logic [5:0]  instr_class;
        logic [2:0]  flow_kind;
        logic        target_valid;
        logic [31:0] target_addr;
        logic        cond_valid;
        logic [3:0]  cond_code;
    } result_t;

    // Extension bytes of an effective address; bad set for illegal or
    // destination immediate whose words are present.
    function automatic logic [3:0] ea_size(input logic [2:0] mode,
        input logic [2:0] rg, input logic long_imm, input logic is_write,
        input logic [3:0] off, input logic [3:0] avail, output logic bad);
        logic [3:0] n;
        logic [4:0] endb;
        begin
            n = 4'd0;
            bad = 1'b0;
            if (mode == 3'd5 || mode == 3'd6 ||
                (mode == 3'd7 && (rg == 3'd0 || rg == 3'd2 || rg == 3'd3)))
                n = 4'd2;
            else if (mode == 3'd7 && rg == 3'd1)
                n = 4'd4;
            else if (mode == 3'd7 && rg == 3'd4)
                n = long_imm ? 4'd4 : 4'd2;
            endb = {1'b0, off} + {1'b0, n};
            if (mode == 3'd7 && rg >= 3'd5)
                bad = 1'b1;
            else if (mode == 3'd7 && rg == 3'd4 && is_write &&
                     endb <= {1'b0, avail})
                bad = 1'b1;
            ea_size = n;
        end
    endfunction

endpackage

// ----- design/m68kpd_front.sv -----
// Front end: classifies the opcode and sizes the extensions into a record.
// Depends on m68kpd_pkg.
module m68kpd_front
    import m68kpd_pkg::*;
(
    input  logic [23:0] pc,
    input  logic [15:0] first_word,
    input  logic [15:0] ext_word_1,
    input  logic [15:0] ext_word_2,
    input  logic [3:0]  avail_bytes,
    output pre_item_t   item
);
    logic [15:0] op;
    logic [2:0]  mode, rg;
    logic [3:0]  top, av, s, d;
    logic        bs, bd;
    logic [1:0]  sc;
    logic [2:0]  om;

    assign op   = first_word;
    assign mode = op[5:3];
    assign rg   = op[2:0];
    assign top  = op[15:12];
    assign sc   = op[7:6];
    assign om   = op[8:6];

    always_comb
    begin
        av = (avail_bytes > 4'd10) ? 4'd10 : avail_bytes;
        item = '0;
        item.pc    = pc;
        item.avail = av;
        item.trunc = (av < 4'd2);
        item.len   = 4'd2;
        item.ok    = 1'b1;
        item.cls   = CL_UNSUPPORTED;
        item.flow  = FL_NONE;
        item.tsel  = TG_NONE;
        s = 4'd0; d = 4'd0;
        bs = 1'b0; bd = 1'b0;

        if (top == 4'h6) begin
            item.cond   = op[11:8];
            item.cvalid = 1'b1;
            item.tval   = {{24{op[7]}}, op[7:0]};
            if (op[7:0] == 8'h00) begin
                if (av < 4'd4) item.ok = 1'b0;
                else begin
                    item.tval = {{16{ext_word_1[15]}}, ext_word_1};
                    item.len  = 4'd4;
                end
            end
            item.cls  = (op[11:8] == 4'd0) ? CL_BRA :
                        ((op[11:8] == 4'd1) ? CL_BSR : CL_BCC);
            item.flow = (op[11:8] == 4'd1) ? FL_DCALL : FL_DBRANCH;
            item.tsel = TG_REL;
        end else if (op[15:4] == 12'h4E4) begin
            item.cls = CL_TRAP;
        end else if (op == 16'h4E75 || op == 16'h4E73 || op == 16'h4E77) begin
            item.cls  = (op == 16'h4E75) ? CL_RTS :
                        ((op == 16'h4E73) ? CL_RTE : CL_RTR);
            item.flow = FL_RETURN;
        end else if (op == 16'h4E71 || op == 16'h4E70 || op == 16'h4E76) begin
            item.cls = (op == 16'h4E71) ? CL_NOP :
                       ((op == 16'h4E70) ? CL_RESET : CL_TRAPV);
        end else if (op == 16'h4E72 || op == 16'h4E74) begin
            item.cls = (op == 16'h4E72) ? CL_STOP : CL_RTD;
            item.len = 4'd4;
        end else if (op[15:3] == 13'h09CA) begin
            item.cls = CL_LINK;
            item.len = 4'd4;
        end else if (op[15:3] == 13'h09CB) begin
            item.cls = CL_UNLK;
        end else if (op[15:4] == 12'h4E6) begin
            item.cls = CL_MOVE_USP;
        end else if (op[15:7] == 9'h09D) begin
            item.cls = op[6] ? CL_JMP : CL_JSR;
            if (mode == 3'd7 && rg == 3'd1 && av >= 4'd6) begin
                item.len  = 4'd6;
                item.tval = {ext_word_1, ext_word_2};
                item.tsel = TG_ABS;
                item.flow = op[6] ? FL_DJUMP : FL_DCALL;
            end else begin
                item.flow = op[6] ? FL_IJUMP : FL_ICALL;
                s = ea_size(mode, rg, 1'b1, 1'b0, 4'd2, av, bs);
                item.len = 4'd2 + s;
            end
        end else if ((op & 16'hF100) == 16'h7000) begin
            item.cls = CL_MOVEQ;
        end else if (top == 4'd1 || top == 4'd2 || top == 4'd3) begin
            s = ea_size(mode, rg, top == 4'd2, 1'b0, 4'd2, av, bs);
            d = ea_size(op[8:6], op[11:9], top == 4'd2, 1'b1, 4'd2 + s, av, bd);
            item.cls = CL_MOVE;
            item.len = 4'd2 + s + d;
        end else if (op[15:12] == 4'h0 && op[8] == 1'b0 && op[11:9] != 3'd4 &&
                     op[11:9] != 3'd7) begin
            item.cls = CL_IMMEDIATE;
            if (op[5:0] == 6'h3C) item.len = 4'd4;
            else if (sc == 2'd3) item.ok = 1'b0;
            else if (sc == 2'd2) begin
                if (av < 4'd6) item.ok = 1'b0;
                else begin
                    s = ea_size(mode, rg, 1'b1, 1'b0, 4'd6, av, bs);
                    item.len = 4'd6 + s;
                end
            end else begin
                if (av < (sc == 2'd0 ? 4'd3 : 4'd4)) item.ok = 1'b0;
                else begin
                    s = ea_size(mode, rg, 1'b0, 1'b0, 4'd4, av, bs);
                    item.len = 4'd4 + s;
                end
            end
        end else if (op[15:8] == 8'h08) begin
            item.cls = CL_STATIC_BIT;
            if (av < 4'd4) item.ok = 1'b0;
            else begin
                s = ea_size(mode, rg, 1'b0, 1'b0, 4'd4, av, bs);
                item.len = 4'd4 + s;
            end
        end else if ((op & 16'hF0F8) == 16'h50C8) begin
            item.cls    = CL_DBCC;
            item.cond   = op[11:8];
            item.cvalid = 1'b1;
            item.len    = 4'd4;
            if (av >= 4'd4) begin
                item.flow = FL_DBRANCH;
                item.tval = {{16{ext_word_1[15]}}, ext_word_1};
                item.tsel = TG_REL;
            end else item.ok = 1'b0;
        end else if ((op & 16'hF0C0) == 16'h50C0) begin
            item.cls = CL_SCC;
            s = ea_size(mode, rg, 1'b0, 1'b1, 4'd2, av, bs);
            item.len = 4'd2 + s;
        end else if (top == 4'h5) begin
            item.cls = op[8] ? CL_SUBQ : CL_ADDQ;
            if (sc == 2'd3) item.ok = 1'b0;
            else begin
                s = ea_size(mode, rg, sc == 2'd2, 1'b0, 4'd2, av, bs);
                item.len = 4'd2 + s;
            end
        end else if ((op & 16'hF1C0) == 16'h41C0) begin
            item.cls = CL_LEA;
            s = ea_size(mode, rg, 1'b0, 1'b0, 4'd2, av, bs);
            item.len = 4'd2 + s;
        end else if (op[15:6] == 10'h121) begin
            item.cls = CL_PEA;
            s = ea_size(mode, rg, 1'b1, 1'b0, 4'd2, av, bs);
            item.len = 4'd2 + s;
        end else if ((op & 16'hFB80) == 16'h4880) begin
            item.cls = CL_MOVEM;
            s = ea_size(mode, rg, 1'b1, 1'b0, 4'd4, av, bs);
            item.len = 4'd4 + s;
        end else if (op[15:6] == 10'h103 || op[15:6] == 10'h113 ||
                     op[15:6] == 10'h11B) begin
            item.cls = CL_MOVE_STATUS;
            s = ea_size(mode, rg, 1'b0, 1'b0, 4'd2, av, bs);
            item.len = 4'd2 + s;
        end else if (op[15:8] == 8'h40 || op[15:8] == 8'h42 ||
                     op[15:8] == 8'h44 || op[15:8] == 8'h46 ||
                     op[15:8] == 8'h4A) begin
            if (sc == 2'd3) item.ok = 1'b0;
            else begin
                item.cls = CL_UNARY;
                s = ea_size(mode, rg, sc == 2'd2, 1'b0, 4'd2, av, bs);
                item.len = 4'd2 + s;
            end
        end else if (top == 4'h8 || top == 4'h9 || top == 4'hB ||
                     top == 4'hC || top == 4'hD) begin
            item.cls = CL_BINARY;
            s = ea_size(mode, rg, (om[1:0] == 2'd2), 1'b0, 4'd2, av, bs);
            item.len = 4'd2 + s;
        end else if (top == 4'hE) begin
            item.cls = CL_SHIFT;
            if (op[7:6] == 2'b11) begin
                s = ea_size(mode, rg, 1'b0, 1'b0, 4'd2, av, bs);
                item.len = 4'd2 + s;
            end
        end else begin
            item.ok = 1'b0;
        end
        // illegal addressing on either operand
        if (bs || bd) item.ok = 1'b0;
    end
endmodule

// ----- design/m68kpd_queue.sv -----
// Small FIFO of records between the stages.
// Depends on m68kpd_pkg.
module m68kpd_queue
    import m68kpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  pre_item_t wdata,
    output logic      full,
    input  logic      rd,
    output pre_item_t rdata,
    output logic      empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pre_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full) mem_reg[wp_reg] <= wdata;
    end

    // pointers wrap at DEPTH
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr && !full)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd && !empty)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
        end
    end
endmodule

// ----- design/m68kpd_back.sv -----
// Back end: length checks, final class/flow, target add, output register.
// Depends on m68kpd_pkg.
module m68kpd_back
    import m68kpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pre_item_t item,
    input  logic      item_valid,
    output logic      item_take,
    input  logic      pop,
    output logic      empty,
    output result_t   res
);
    result_t r_next, res_reg;
    logic    valid_reg;
    logic    bad;

    assign item_take = item_valid && (!valid_reg || pop);
    assign empty = !valid_reg;
    assign res   = res_reg;

    always_comb
    begin
        r_next = '0;
        bad = 1'b0;
        if (item.trunc) begin
            r_next.length_bytes = item.avail;
            r_next.instr_class  = CL_TRUNC;
            r_next.flow_kind    = FL_NONE;
        end else begin
            bad = (item.len > item.avail) || item.len[0];
            r_next.length_bytes = bad ? 4'd2 : item.len;
            r_next.supported    = item.ok && !bad;
            r_next.instr_class  = r_next.supported ? item.cls : CL_UNSUPPORTED;
            r_next.flow_kind    = r_next.supported ? item.flow : FL_UNSUP;
            r_next.target_valid = (item.tsel != TG_NONE);
            r_next.target_addr  = (item.tsel == TG_REL) ?
                {8'd0, item.pc} + 32'd2 + item.tval :
                ((item.tsel == TG_ABS) ? item.tval : 32'd0);
            r_next.cond_valid   = item.cvalid;
            r_next.cond_code    = item.cvalid ? item.cond : 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take) res_reg <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (item_take) valid_reg <= 1'b1;
        else if (pop) valid_reg <= 1'b0;
    end
endmodule

// ----- design/m68k_instruction_predecoder.sv -----
// Top level of the 68000 instruction pre-decoder: front, queue, back.
// Depends on m68kpd_pkg, m68kpd_front, m68kpd_queue, m68kpd_back.
//
//  channel  | handshake        | payload
//  input    | push / full      | pc, first_word, ext_word_1..4, avail_bytes
//  result   | pop / empty      | length_bytes .. cond_code
//
// One item per cycle sustained while pop is held; an item reaches the result
// ports through the queue write, then the back-end output register.
// full rises when the QUEUE_DEPTH-entry queue is full; it drains at one item
// per cycle while pop is held or the output register is free.
// Reset empties the queue and the output register.
module m68k_instruction_predecoder
    import m68kpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] pc,
    input  logic [15:0] first_word,
    input  logic [15:0] ext_word_1,
    input  logic [15:0] ext_word_2,
    input  logic [15:0] ext_word_3,
    input  logic [15:0] ext_word_4,
    input  logic [3:0]  avail_bytes,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  length_bytes,
    output logic        supported,
    output logic [5:0]  instr_class,
    output logic [2:0]  flow_kind,
    output logic        target_valid,
    output logic [31:0] target_addr,
    output logic        cond_valid,
    output logic [3:0]  cond_code
);
    pre_item_t f_item, q_item;
    logic      q_empty, q_take;
    result_t   res;
    logic      unused_ext;

    // words 3 and 4 never hold a field this block reports
    assign unused_ext = ^{ext_word_3, ext_word_4};

    m68kpd_front u_front (
        .pc(pc), .first_word(first_word), .ext_word_1(ext_word_1),
        .ext_word_2(ext_word_2), .avail_bytes(avail_bytes), .item(f_item)
    );

    m68kpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(push), .wdata(f_item), .full(full),
        .rd(q_take), .rdata(q_item), .empty(q_empty)
    );

    m68kpd_back u_back (
        .clk(clk), .rst_n(rst_n), .item(q_item), .item_valid(!q_empty),
        .item_take(q_take), .pop(pop), .empty(empty), .res(res)
    );

    assign length_bytes = res.length_bytes;
    assign supported    = res.supported | (unused_ext & 1'b0);
    assign instr_class  = res.instr_class;
    assign flow_kind    = res.flow_kind;
    assign target_valid = res.target_valid;
    assign target_addr  = res.target_addr;
    assign cond_valid   = res.cond_valid;
    assign cond_code    = res.cond_code;
endmodule
